>>> sv/rsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsb_pkg;

    localparam int CW        = 24;  // coordinate width, Q16.8
    localparam int DW        = 16;  // direction width, Q2.14
    localparam int LW        = 23;  // length / box extent width
    localparam int DIR_FRAC  = 14;  // shift from dir * length back to Q16.8
    localparam int PW        = 40;  // direction times length product
    localparam int DXW       = 26;  // segment delta
    localparam int EW        = 27;  // widened coordinate for the edge maths
    localparam int NW        = 56;  // divider dividend / remainder
    localparam int QB        = 26;  // divider quotient bits
    localparam int D2W       = 56;  // squared distance
    localparam int RB        = 28;  // square root bits

    localparam int EDGE_LAT  = 3 + QB;
    localparam int TOTAL_LAT = 2 + EDGE_LAT + 4 + RB + 1;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_BOX_LEFT   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BOX_TOP    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BOX_WIDTH  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_BOX_HEIGHT = 2'd3;

    localparam logic [CW-1:0] DIST_MAX = {CW{1'b1}};
    localparam logic signed [EW-1:0] COORD_MAX = EW'((1 << (CW - 1)) - 1);
    localparam logic signed [EW-1:0] COORD_MIN = -EW'(1 << (CW - 1));

    // one edge test: axis a is the edge normal, axis b runs along the edge
    typedef struct packed {
        logic signed [EW-1:0] a1;
        logic signed [EW-1:0] b1;
        logic signed [EW-1:0] da;
        logic signed [EW-1:0] db;
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] ext;
    } rsb_edge_in_t;

    // data riding alongside the divider
    typedef struct packed {
        logic                 hit;
        logic                 neg;
        logic signed [EW-1:0] b1;
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] ta;
    } rsb_side_t;

    // data riding alongside the square root
    typedef struct packed {
        logic                 found;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } rsb_hit_t;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [EW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > COORD_MAX) begin
            r = CW'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            r = CW'(COORD_MIN);
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/rsb_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rsb_div (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [rsb_pkg::NW-1:0]   num_in,
    input  wire logic [rsb_pkg::EW-1:0]   den_in,
    input  wire rsb_pkg::rsb_side_t       side_in,
    output logic [rsb_pkg::QB-1:0]        q_out,
    output rsb_pkg::rsb_side_t            side_out
);

    localparam int NW = rsb_pkg::NW;
    localparam int EW = rsb_pkg::EW;
    localparam int QB = rsb_pkg::QB;

    // restoring division, one quotient bit per stage
    logic [NW-1:0]      rem_reg  [QB-1];
    logic [EW-1:0]      den_reg  [QB-1];
    logic [QB-1:0]      q_reg    [QB];
    rsb_pkg::rsb_side_t side_reg [QB];

    genvar s;
    for (s = 0; s < QB; s++) begin : g_stage
        localparam int BIT = QB - 1 - s;
        logic [NW-1:0]      rem_cur;
        logic [EW-1:0]      den_cur;
        logic [QB-1:0]      q_cur;
        rsb_pkg::rsb_side_t side_cur;
        logic [NW-1:0]      sub;
        logic [NW-1:0]      rem_next;
        logic [QB-1:0]      q_next;

        if (s == 0) begin : g_first
            assign rem_cur  = num_in;
            assign den_cur  = den_in;
            assign q_cur    = '0;
            assign side_cur = side_in;
        end else begin : g_rest
            assign rem_cur  = rem_reg[s-1];
            assign den_cur  = den_reg[s-1];
            assign q_cur    = q_reg[s-1];
            assign side_cur = side_reg[s-1];
        end

        assign sub = NW'(den_cur) << BIT;

        always_comb begin
            if (rem_cur >= sub) begin
                rem_next = rem_cur - sub;
                q_next   = q_cur | (QB'(1) << BIT);
            end else begin
                rem_next = rem_cur;
                q_next   = q_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[s]    <= q_next;
                side_reg[s] <= side_cur;
            end
        end

        if (s < QB - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_cur;
                end
            end
        end
    end

    assign q_out    = q_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule
`default_nettype wire

>>> sv/rsb_edge.sv
`timescale 1ns / 1ps
`default_nettype none
module rsb_edge (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire rsb_pkg::rsb_edge_in_t edge_in,
    output logic [rsb_pkg::QB-1:0]     q_out,
    output rsb_pkg::rsb_side_t         side_out
);

    localparam int EW = rsb_pkg::EW;
    localparam int NW = rsb_pkg::NW;

    // setup stage
    logic signed [EW-1:0] t_reg, ta_reg, da_reg, db_reg, lom_reg, him_reg, b1_reg, e_reg;
    logic                 ok_reg;
    logic signed [EW-1:0] t_next, ta_next, da_next, lom_next, him_next;
    logic                 ok_next;

    always_comb begin
        ta_next  = edge_in.e - edge_in.a1;
        if (edge_in.da < 0) begin
            da_next = -edge_in.da;
            t_next  = -ta_next;
        end else begin
            da_next = edge_in.da;
            t_next  = ta_next;
        end
        lom_next = edge_in.lo - edge_in.b1;
        him_next = edge_in.lo + edge_in.ext - edge_in.b1;
        ok_next  = (edge_in.ext != '0) && (edge_in.da != '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= t_next;
            ta_reg  <= ta_next;
            da_reg  <= da_next;
            db_reg  <= edge_in.db;
            lom_reg <= lom_next;
            him_reg <= him_next;
            b1_reg  <= edge_in.b1;
            e_reg   <= edge_in.e;
            ok_reg  <= ok_next;
        end
    end

    // product stage
    logic signed [2*EW-1:0] num_reg, lop_reg, hip_reg;
    logic signed [EW-1:0]   da2_reg, b12_reg, e2_reg, ta2_reg;
    logic                   ok2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= (2*EW)'(t_reg) * (2*EW)'(db_reg);
            lop_reg <= (2*EW)'(lom_reg) * (2*EW)'(da_reg);
            hip_reg <= (2*EW)'(him_reg) * (2*EW)'(da_reg);
            ok2_reg <= ok_reg && (t_reg >= 0) && (t_reg <= da_reg);
            da2_reg <= da_reg;
            b12_reg <= b1_reg;
            e2_reg  <= e_reg;
            ta2_reg <= ta_reg;
        end
    end

    // hit decision and divider operands
    logic [NW-1:0]      n_reg, n_next;
    logic [EW-1:0]      d_reg;
    rsb_pkg::rsb_side_t side_reg, side_next;
    logic [2*EW-1:0]    mag;

    always_comb begin
        mag            = (num_reg < 0) ? $unsigned(-num_reg) : $unsigned(num_reg);
        n_next         = (NW'(mag) << 1) + NW'($unsigned(da2_reg));
        side_next.hit  = ok2_reg && (num_reg >= lop_reg) && (num_reg <= hip_reg);
        side_next.neg  = num_reg < 0;
        side_next.b1   = b12_reg;
        side_next.e    = e2_reg;
        side_next.ta   = ta2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            d_reg    <= $unsigned(da2_reg) << 1;
            side_reg <= side_next;
        end
    end

    rsb_div u_div (
        .aclk     (aclk),
        .en       (en),
        .num_in   (n_reg),
        .den_in   (d_reg),
        .side_in  (side_reg),
        .q_out    (q_out),
        .side_out (side_out)
    );

endmodule
`default_nettype wire

>>> sv/rsb_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module rsb_sqrt (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [rsb_pkg::D2W-1:0] val_in,
    input  wire rsb_pkg::rsb_hit_t       side_in,
    output logic [rsb_pkg::RB-1:0]       root_out,
    output logic [rsb_pkg::D2W-1:0]      rem_out,
    output rsb_pkg::rsb_hit_t            side_out
);

    localparam int VW = rsb_pkg::D2W;
    localparam int RB = rsb_pkg::RB;

    // digit recurrence, one root bit per stage, remainder kept as v - root^2
    logic [VW-1:0]     rem_reg  [RB];
    logic [RB-1:0]     root_reg [RB];
    rsb_pkg::rsb_hit_t side_reg [RB];

    genvar s;
    for (s = 0; s < RB; s++) begin : g_stage
        localparam int BIT = RB - 1 - s;
        logic [VW-1:0]     rem_cur, trial;
        logic [RB-1:0]     root_cur;
        rsb_pkg::rsb_hit_t side_cur;

        if (s == 0) begin : g_first
            assign rem_cur  = val_in;
            assign root_cur = '0;
            assign side_cur = side_in;
        end else begin : g_rest
            assign rem_cur  = rem_reg[s-1];
            assign root_cur = root_reg[s-1];
            assign side_cur = side_reg[s-1];
        end

        assign trial = (VW'(root_cur) << (BIT + 1)) | (VW'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= side_cur;
                if (rem_cur >= trial) begin
                    rem_reg[s]  <= rem_cur - trial;
                    root_reg[s] <= root_cur | (RB'(1) << BIT);
                end else begin
                    rem_reg[s]  <= rem_cur;
                    root_reg[s] <= root_cur;
                end
            end
        end
    end

    assign root_out = root_reg[RB-1];
    assign rem_out  = rem_reg[RB-1];
    assign side_out = side_reg[RB-1];

endmodule
`default_nettype wire

>>> sv/ray_segment_box_nearest_hit.sv
`timescale 1ns / 1ps
`default_nettype none
// nearest crossing of a ray segment with a configured axis-aligned box
//
// cfg channel: cfg_index selects box_left, box_top, box_width or box_height,
// cfg_data carries the value; always ready, write only while the block idles
// s channel: one ray per transfer (start point Q16.8, direction Q2.14, length)
// m channel: one result per ray (hit flag, nearest hit point, distance)
//
// on the way from an s transfer to its m result, two stages form
// the segment delta, each edge takes three stages of setup and products and
// 26 stages of its pipelined divider, four stages pick the nearest hit and
// the 28 stage square root plus the output register give the distance
// throughput is one ray per cycle while the m side does not stall
//
// reset clears the box registers and empties the pipeline
// when the m side stalls with a result waiting the whole pipeline holds
// and s_ready drops; nothing is lost or repeated
module ray_segment_box_nearest_hit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rsb_pkg::CFG_IW-1:0]        cfg_index,
    input  wire logic [rsb_pkg::CW-1:0]            cfg_data,
    // rays in
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [rsb_pkg::CW-1:0]     s_start_x,
    input  wire logic signed [rsb_pkg::CW-1:0]     s_start_y,
    input  wire logic signed [rsb_pkg::DW-1:0]     s_dir_x,
    input  wire logic signed [rsb_pkg::DW-1:0]     s_dir_y,
    input  wire logic [rsb_pkg::LW-1:0]            s_ray_length,
    // results out
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_hit_found,
    output logic signed [rsb_pkg::CW-1:0]          m_hit_x,
    output logic signed [rsb_pkg::CW-1:0]          m_hit_y,
    output logic [rsb_pkg::CW-1:0]                 m_hit_distance
);

    localparam int CW  = rsb_pkg::CW;
    localparam int LW  = rsb_pkg::LW;
    localparam int PW  = rsb_pkg::PW;
    localparam int DXW = rsb_pkg::DXW;
    localparam int EW  = rsb_pkg::EW;
    localparam int QB  = rsb_pkg::QB;
    localparam int D2W = rsb_pkg::D2W;
    localparam int RB  = rsb_pkg::RB;
    localparam int LAT = rsb_pkg::TOTAL_LAT;

    // box registers
    logic signed [CW-1:0] box_left_reg, box_top_reg;
    logic [LW-1:0]        box_width_reg, box_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rsb_pkg::CFG_BOX_LEFT:   box_left_reg   <= cfg_data;
                rsb_pkg::CFG_BOX_TOP:    box_top_reg    <= cfg_data;
                rsb_pkg::CFG_BOX_WIDTH:  box_width_reg  <= cfg_data[LW-1:0];
                rsb_pkg::CFG_BOX_HEIGHT: box_height_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // one stall for the whole pipeline, valid bits shift alongside the data
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: direction times length
    logic signed [PW-1:0] prod_x_reg, prod_y_reg;
    logic signed [CW-1:0] x1_reg, y1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= PW'(s_dir_x) * PW'($signed({1'b0, s_ray_length}));
            prod_y_reg <= PW'(s_dir_y) * PW'($signed({1'b0, s_ray_length}));
            x1_reg     <= s_start_x;
            y1_reg     <= s_start_y;
        end
    end

    // stage 2: back to Q16.8, round half away from zero
    function automatic logic signed [DXW-1:0] round_delta(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = (p < 0) ? $unsigned(-p) : $unsigned(p);
        q   = (mag + (PW'(1) << (rsb_pkg::DIR_FRAC - 1))) >> rsb_pkg::DIR_FRAC;
        return (p < 0) ? -$signed(q[DXW-1:0]) : $signed(q[DXW-1:0]);
    endfunction

    logic signed [DXW-1:0] dx_reg, dy_reg;
    logic signed [CW-1:0]  x2_reg, y2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= round_delta(prod_x_reg);
            dy_reg <= round_delta(prod_y_reg);
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
        end
    end

    // edge tests in order top, left, right, bottom
    logic signed [EW-1:0] left_w, top_w, right_w, bottom_w, wid_w, hgt_w;
    logic signed [EW-1:0] x_w, y_w, dx_w, dy_w;
    rsb_pkg::rsb_edge_in_t edge_in [4];
    logic [QB-1:0]         edge_q  [4];
    rsb_pkg::rsb_side_t    edge_sd [4];

    always_comb begin
        left_w   = EW'(box_left_reg);
        top_w    = EW'(box_top_reg);
        wid_w    = EW'($signed({1'b0, box_width_reg}));
        hgt_w    = EW'($signed({1'b0, box_height_reg}));
        right_w  = left_w + wid_w;
        bottom_w = top_w + hgt_w;
        x_w      = EW'(x2_reg);
        y_w      = EW'(y2_reg);
        dx_w     = EW'(dx_reg);
        dy_w     = EW'(dy_reg);
        // horizontal edges: normal along y
        edge_in[0] = '{a1: y_w, b1: x_w, da: dy_w, db: dx_w, e: top_w,
                       lo: left_w, ext: wid_w};
        edge_in[3] = '{a1: y_w, b1: x_w, da: dy_w, db: dx_w, e: bottom_w,
                       lo: left_w, ext: wid_w};
        // vertical edges: normal along x
        edge_in[1] = '{a1: x_w, b1: y_w, da: dx_w, db: dy_w, e: left_w,
                       lo: top_w, ext: hgt_w};
        edge_in[2] = '{a1: x_w, b1: y_w, da: dx_w, db: dy_w, e: right_w,
                       lo: top_w, ext: hgt_w};
    end

    genvar k;
    for (k = 0; k < 4; k++) begin : g_edge
        rsb_edge u_edge (
            .aclk     (aclk),
            .en       (en),
            .edge_in  (edge_in[k]),
            .q_out    (edge_q[k]),
            .side_out (edge_sd[k])
        );
    end

    // stage a: squares of both offsets and the along-edge coordinate
    // the offset along the edge is the rounded quotient itself, so its square
    // does not need the sign
    logic [2*QB-1:0] qsq_reg [4];
    logic [2*EW-1:0] tsq_reg [4];
    logic signed [EW-1:0] ca_reg [4];
    logic signed [EW-1:0] ea_reg [4];
    logic            ha_reg  [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                qsq_reg[i] <= (2*QB)'(edge_q[i]) * (2*QB)'(edge_q[i]);
                tsq_reg[i] <= $unsigned((2*EW)'(edge_sd[i].ta) * (2*EW)'(edge_sd[i].ta));
                ca_reg[i]  <= edge_sd[i].neg ? edge_sd[i].b1 - EW'(edge_q[i])
                                             : edge_sd[i].b1 + EW'(edge_q[i]);
                ea_reg[i]  <= edge_sd[i].e;
                ha_reg[i]  <= edge_sd[i].hit;
            end
        end
    end

    // stage b: squared distance, saturated hit point
    logic [D2W-1:0]       d2b_reg [4];
    logic signed [CW-1:0] pxb_reg [4];
    logic signed [CW-1:0] pyb_reg [4];
    logic                 hb_reg  [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                d2b_reg[i] <= D2W'(qsq_reg[i]) + D2W'(tsq_reg[i]);
                hb_reg[i]  <= ha_reg[i];
                if (i == 0 || i == 3) begin
                    pxb_reg[i] <= rsb_pkg::sat_coord(ca_reg[i]);
                    pyb_reg[i] <= rsb_pkg::sat_coord(ea_reg[i]);
                end else begin
                    pxb_reg[i] <= rsb_pkg::sat_coord(ea_reg[i]);
                    pyb_reg[i] <= rsb_pkg::sat_coord(ca_reg[i]);
                end
            end
        end
    end

    // stages c and d: nearest hit, the later edge wins only when the earlier one missed or it is strictly nearer
    logic [D2W-1:0]       d2c_reg [2];
    logic signed [CW-1:0] pxc_reg [2];
    logic signed [CW-1:0] pyc_reg [2];
    logic                 hc_reg  [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                if (!hb_reg[2*j] || (hb_reg[2*j+1] && d2b_reg[2*j+1] < d2b_reg[2*j])) begin
                    d2c_reg[j] <= d2b_reg[2*j+1];
                    pxc_reg[j] <= pxb_reg[2*j+1];
                    pyc_reg[j] <= pyb_reg[2*j+1];
                    hc_reg[j]  <= hb_reg[2*j+1];
                end else begin
                    d2c_reg[j] <= d2b_reg[2*j];
                    pxc_reg[j] <= pxb_reg[2*j];
                    pyc_reg[j] <= pyb_reg[2*j];
                    hc_reg[j]  <= hb_reg[2*j];
                end
            end
        end
    end

    logic [D2W-1:0]    d2d_reg;
    rsb_pkg::rsb_hit_t hitd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!hc_reg[0] || (hc_reg[1] && d2c_reg[1] < d2c_reg[0])) begin
                d2d_reg  <= d2c_reg[1];
                hitd_reg <= '{found: hc_reg[1], x: pxc_reg[1], y: pyc_reg[1]};
            end else begin
                d2d_reg  <= d2c_reg[0];
                hitd_reg <= '{found: hc_reg[0], x: pxc_reg[0], y: pyc_reg[0]};
            end
        end
    end

    // distance: square root of the winning squared distance
    logic [RB-1:0]     root_w;
    logic [D2W-1:0]    rem_w;
    rsb_pkg::rsb_hit_t hits_w;

    rsb_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .val_in   (d2d_reg),
        .side_in  (hitd_reg),
        .root_out (root_w),
        .rem_out  (rem_w),
        .side_out (hits_w)
    );

    // output register: round to nearest, saturate, zero when nothing hit
    logic [RB:0]          dist_w;
    logic                 found_reg;
    logic signed [CW-1:0] hx_reg, hy_reg;
    logic [CW-1:0]        hd_reg;

    assign dist_w = {1'b0, root_w} + (RB+1)'(rem_w > D2W'(root_w));

    always_ff @(posedge aclk) begin
        if (en) begin
            found_reg <= hits_w.found;
            if (hits_w.found) begin
                hx_reg <= hits_w.x;
                hy_reg <= hits_w.y;
                hd_reg <= (dist_w > (RB+1)'(rsb_pkg::DIST_MAX)) ? rsb_pkg::DIST_MAX
                                                                : dist_w[CW-1:0];
            end else begin
                hx_reg <= '0;
                hy_reg <= '0;
                hd_reg <= '0;
            end
        end
    end

    assign m_hit_found    = found_reg;
    assign m_hit_x        = hx_reg;
    assign m_hit_y        = hy_reg;
    assign m_hit_distance = hd_reg;

endmodule
`default_nettype wire

>>> verif/ray_segment_box_nearest_hit_tb.sv
`timescale 1ns / 1ps
module ray_segment_box_nearest_hit_tb;

    localparam int CW        = rsb_pkg::CW;
    localparam int DW        = rsb_pkg::DW;
    localparam int LW        = rsb_pkg::LW;
    localparam int CFG_IW    = rsb_pkg::CFG_IW;
    localparam int DIR_FRAC  = rsb_pkg::DIR_FRAC;
    localparam int TOTAL_LAT = rsb_pkg::TOTAL_LAT;
    localparam logic [CW-1:0] DIST_MAX = rsb_pkg::DIST_MAX;

    // one ray as it goes into the block
    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic [LW-1:0]        len;
    } ray_t;

    // one result as it leaves the block
    typedef struct {
        logic                 found;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [CW-1:0]        distance;
    } hit_t;

    // directed row: expected result typed in only where it is obvious
    typedef struct {
        bit   at_reset;
        bit   known;
        ray_t ray;
        hit_t hit;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IW-1:0] cfg_index = rsb_pkg::CFG_BOX_LEFT;
    logic [CW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_start_x = '0;
    logic signed [CW-1:0] s_start_y = '0;
    logic signed [DW-1:0] s_dir_x = '0;
    logic signed [DW-1:0] s_dir_y = '0;
    logic [LW-1:0] s_ray_length = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit_found;
    logic signed [CW-1:0] m_hit_x;
    logic signed [CW-1:0] m_hit_y;
    logic [CW-1:0] m_hit_distance;

    ray_segment_box_nearest_hit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_ray_length(s_ray_length),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit_found(m_hit_found), .m_hit_x(m_hit_x), .m_hit_y(m_hit_y),
        .m_hit_distance(m_hit_distance)
    );

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow copy of the box registers
    longint box_l = 0;
    longint box_t = 0;
    longint box_w = 0;
    longint box_h = 0;

    hit_t   pending_hits[$];
    int     errors = 0;
    int     rays_sent = 0;
    int     results_seen = 0;
    int     hits_seen = 0;
    int     sat_seen = 0;
    bit     calm = 1'b0;       // no idling on either side while set
    bit     hold_req = 1'b0;   // asks the receiver for one long hold-off

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // rounded division, ties away from zero, divisor positive
    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    // crossing of an edge normal to axis a at position e, running lo .. lo+ext
    function automatic bit edge_cross(longint a1, longint b1, longint da, longint db,
                                      longint e, longint lo, longint ext,
                                      output longint bout);
        longint t;
        longint num;
        bout = 0;
        if (ext == 0 || da == 0) return 1'b0;
        t = e - a1;
        if (da < 0) begin
            da = -da;
            t = -t;
        end
        if (t < 0 || t > da) return 1'b0;
        num = t * db;
        if (num < (lo - b1) * da || num > (lo + ext - b1) * da) return 1'b0;
        bout = b1 + round_div(num, da);
        return 1'b1;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > 64'sd8388607) return 24'sd8388607;
        if (v < -64'sd8388608) return -24'sd8388608;
        return v[CW-1:0];
    endfunction

    function automatic hit_t nearest_hit(ray_t r);
        longint dx;
        longint dy;
        longint right;
        longint bottom;
        longint c;
        longint px;
        longint py;
        longint bx;
        longint by;
        longint unsigned d2;
        longint unsigned best;
        longint unsigned v;
        longint unsigned root;
        longint unsigned bitv;
        bit crossed;
        hit_t h;
        h = '{1'b0, '0, '0, '0};
        dx = round_div(longint'(r.ddx) * longint'(r.len), 64'sd1 << DIR_FRAC);
        dy = round_div(longint'(r.ddy) * longint'(r.len), 64'sd1 << DIR_FRAC);
        right = box_l + box_w;
        bottom = box_t + box_h;
        best = 0;
        bx = 0;
        by = 0;
        // top, left, right, bottom; strictly nearer wins so ties keep the earlier edge
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    crossed = edge_cross(r.sy, r.sx, dy, dx, box_t, box_l, box_w, c);
                    px = c; py = box_t;
                end
                1: begin
                    crossed = edge_cross(r.sx, r.sy, dx, dy, box_l, box_t, box_h, c);
                    px = box_l; py = c;
                end
                2: begin
                    crossed = edge_cross(r.sx, r.sy, dx, dy, right, box_t, box_h, c);
                    px = right; py = c;
                end
                default: begin
                    crossed = edge_cross(r.sy, r.sx, dy, dx, bottom, box_l, box_w, c);
                    px = c; py = bottom;
                end
            endcase
            if (crossed) begin
                d2 = longint'(px - r.sx) * longint'(px - r.sx)
                   + longint'(py - r.sy) * longint'(py - r.sy);
                if (!h.found || d2 < best) begin
                    h.found = 1'b1;
                    best = d2;
                    bx = px;
                    by = py;
                end
            end
        end
        if (!h.found) return h;
        // integer square root, then round to nearest
        v = best;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (best - root * root > root) root++;
        if (root > 64'd16777215) root = 64'd16777215;
        h.x = clamp_coord(bx);
        h.y = clamp_coord(by);
        h.distance = root[CW-1:0];
        return h;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one register write; valid is left up for the next write of a burst
    task automatic write_reg(logic [CFG_IW-1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CW-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rsb_pkg::CFG_BOX_LEFT:  box_l = longint'($signed(value[CW-1:0]));
            rsb_pkg::CFG_BOX_TOP:   box_t = longint'($signed(value[CW-1:0]));
            rsb_pkg::CFG_BOX_WIDTH: box_w = longint'(value[LW-1:0]);
            default:                box_h = longint'(value[LW-1:0]);
        endcase
    endtask

    task automatic set_box(longint l, longint t, longint w, longint h);
        write_reg(rsb_pkg::CFG_BOX_LEFT, l);
        write_reg(rsb_pkg::CFG_BOX_TOP, t);
        write_reg(rsb_pkg::CFG_BOX_WIDTH, w);
        write_reg(rsb_pkg::CFG_BOX_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // one ray transfer; valid stays up across back-to-back transfers
    task automatic send_ray(ray_t r, bit known, hit_t typed);
        int gap;
        hit_t want;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_x <= r.sx;
        s_start_y <= r.sy;
        s_dir_x <= r.ddx;
        s_dir_y <= r.ddy;
        s_ray_length <= r.len;
        do @(posedge aclk); while (!s_ready);
        want = known ? typed : nearest_hit(r);
        pending_hits = {pending_hits, want};
        rays_sent++;
    endtask

    // drain: every result back, then let the pipeline go quiet
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (TOTAL_LAT + 8) @(posedge aclk);
    endtask

    // mostly rays aimed around the box, some with a zero component, the rest noise
    function automatic ray_t random_ray();
        ray_t r;
        longint span_x;
        longint span_y;
        longint reach;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            span_x = 2 * box_w + 1025;
            span_y = 2 * box_h + 1025;
            r.sx = clamp_coord(box_l - box_w / 2 - 512
                               + longint'($urandom % longint'(span_x)));
            r.sy = clamp_coord(box_t - box_h / 2 - 512
                               + longint'($urandom % longint'(span_y)));
            r.ddx = DW'($urandom);
            r.ddy = DW'($urandom);
            if (pick == 0) r.ddx = '0;
            if (pick == 1) r.ddy = '0;
            reach = 2 * (box_w > box_h ? box_w : box_h) + 2048;
            if (reach > 64'd8388607) reach = 64'd8388607;
            r.len = LW'($urandom % longint'(reach + 1));
        end else begin
            r.sx = CW'($urandom);
            r.sy = CW'($urandom);
            r.ddx = DW'($urandom);
            r.ddy = DW'($urandom);
            r.len = LW'($urandom);
        end
        return r;
    endfunction

    task automatic random_phase(int n);
        hit_t none;
        none = '{1'b0, '0, '0, '0};
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            send_ray(random_ray(), 1'b0, none);
        end
        calm = 1'b0;
        drain();
    endtask

    // ---------------------------------------------------------------
    // directed table; box for the non-reset rows is -4.0 .. 4.0 each way
    // ---------------------------------------------------------------
    localparam int N_ROWS = 16;
    row_t rows[N_ROWS];

    initial begin
        hit_t z;
        z = '{1'b0, '0, '0, '0};
        // reset box has zero extent, so nothing can hit
        rows[0]  = '{1, 1, '{24'sd0, 24'sd0, 16'sd16384, 16'sd0, 23'd2560}, z};
        rows[1]  = '{1, 1, '{-24'sd8388608, 24'sd8388607, -16'sd32768, 16'sd32767,
                             23'd8388607}, z};
        // zero length and zero direction give no delta at all
        rows[2]  = '{0, 1, '{24'sd0, 24'sd0, 16'sd16384, 16'sd16384, 23'd0}, z};
        rows[3]  = '{0, 1, '{24'sd0, 24'sd0, 16'sd0, 16'sd0, 23'd8388607}, z};
        // straight out of the centre through each edge
        rows[4]  = '{0, 0, '{24'sd0, 24'sd0, 16'sd16384, 16'sd0, 23'd2560}, z};
        rows[5]  = '{0, 0, '{24'sd0, 24'sd0, -16'sd16384, 16'sd0, 23'd2560}, z};
        rows[6]  = '{0, 0, '{24'sd0, 24'sd0, 16'sd0, -16'sd16384, 23'd2560}, z};
        rows[7]  = '{0, 0, '{24'sd0, 24'sd0, 16'sd0, 16'sd16384, 23'd2560}, z};
        // through a corner: equal distance, earlier edge kept
        rows[8]  = '{0, 0, '{24'sd0, 24'sd0, 16'sd16384, 16'sd16384, 23'd4096}, z};
        // from outside across the whole box, near edge first
        rows[9]  = '{0, 0, '{-24'sd3000, 24'sd100, 16'sd16384, 16'sd0, 23'd8000}, z};
        // stops short, ends exactly on the edge, starts on the edge
        rows[10] = '{0, 0, '{24'sd0, 24'sd0, 16'sd16384, 16'sd0, 23'd768}, z};
        rows[11] = '{0, 0, '{24'sd0, 24'sd0, 16'sd16384, 16'sd0, 23'd1024}, z};
        rows[12] = '{0, 0, '{24'sd1024, 24'sd0, 16'sd16384, 16'sd3000, 23'd500}, z};
        // field extremes, then a diagonal from outside the box
        rows[13] = '{0, 0, '{24'sd8388607, -24'sd8388608, -16'sd32768, 16'sd32767,
                             23'd8388607}, z};
        rows[14] = '{0, 0, '{-24'sd8388608, 24'sd8388607, 16'sd32767, -16'sd32768,
                             23'd8388607}, z};
        rows[15] = '{0, 0, '{-24'sd5000, -24'sd5000, 16'sd11585, 16'sd11585,
                             23'd4096}, z};
    end

    // ---------------------------------------------------------------
    // result side: random stalls plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                // long enough for the pipeline to fill and push back on s_ready
                repeat (TOTAL_LAT * 5) @(posedge aclk);
            end
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each result transfer against the oldest prediction
    always @(posedge aclk) begin
        hit_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_hit_found) hits_seen++;
            if (m_hit_distance == DIST_MAX) sat_seen++;
            if (pending_hits.size() == 0) begin
                $display("%0t: result with none expected: found %0d x %0d y %0d dist %0d",
                         $time, m_hit_found, m_hit_x, m_hit_y, m_hit_distance);
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (m_hit_found !== want.found) begin
                    $display("%0t: hit_found expected %0d actual %0d",
                             $time, want.found, m_hit_found);
                    errors++;
                end
                if (m_hit_x !== want.x) begin
                    $display("%0t: hit_x expected %0d actual %0d", $time, want.x, m_hit_x);
                    errors++;
                end
                if (m_hit_y !== want.y) begin
                    $display("%0t: hit_y expected %0d actual %0d", $time, want.y, m_hit_y);
                    errors++;
                end
                if (m_hit_distance !== want.distance) begin
                    $display("%0t: hit_distance expected %0d actual %0d",
                             $time, want.distance, m_hit_distance);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        hit_t none;
        none = '{1'b0, '0, '0, '0};
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset box first, then the small centred box
        foreach (rows[i]) if (rows[i].at_reset) send_ray(rows[i].ray, rows[i].known, rows[i].hit);
        drain();
        set_box(-1024, -1024, 2048, 2048);
        foreach (rows[i]) if (!rows[i].at_reset) send_ray(rows[i].ray, rows[i].known, rows[i].hit);
        drain();

        // same box at random, opening with a long stall on the result side
        hold_req = 1'b1;
        calm = 1'b1;
        for (int i = 0; i < 150; i++) send_ray(random_ray(), 1'b0, none);
        calm = 1'b0;
        drain();
        random_phase(170);

        // zero-width box: top and bottom edges drop out
        set_box(-5000, 300, 0, 4000);
        random_phase(300);
        // zero-height box
        set_box(7000, -2000, 3000, 0);
        random_phase(250);
        // extreme boxes; the second one's far corner lies beyond the coordinate range
        set_box(-8388608, -8388608, 8388607, 8388607);
        random_phase(300);
        set_box(8388607, 8388607, 8388607, 8388607);
        random_phase(300);
        // a randomly placed box of moderate size
        set_box($signed($urandom_range(0, 200000)) - 100000,
                $signed($urandom_range(0, 200000)) - 100000,
                $urandom_range(1, 60000), $urandom_range(1, 60000));
        random_phase(450);

        $display("covered %0d rays, %0d results, %0d hits, %0d saturated distances",
                 rays_sent, results_seen, hits_seen, sat_seen);
        $display("box settings: reset, centred, zero width, zero height, extremes, random");
        if (errors == 0) begin
            $display("ray_segment_box_nearest_hit regression: pass");
        end else begin
            $display("ray_segment_box_nearest_hit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("ray_segment_box_nearest_hit regression: fail");
        $finish;
    end

endmodule

>>> files.f
sv/rsb_pkg.sv
sv/rsb_div.sv
sv/rsb_edge.sv
sv/rsb_sqrt.sv
sv/ray_segment_box_nearest_hit.sv
verif/ray_segment_box_nearest_hit_tb.sv
